// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spiral fill matrix RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SFM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/sfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Spiral fill matrix package
// Field widths, request and register codes, and shared types.
// ----------------------------------------------------------------------------
package sfm_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 6;
   localparam int REQ_W       = 2;
   localparam int SIZE_W      = 7;
   localparam int SIZE_CMP_W  = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int EPOCH_W     = 3;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int MAX_COLS_DEFAULT = 64;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COL_COUNT = 2'd1;

   localparam logic [1:0] HEAD_RIGHT = 2'd0;
   localparam logic [1:0] HEAD_DOWN  = 2'd1;
   localparam logic [1:0] HEAD_LEFT  = 2'd2;
   localparam logic [1:0] HEAD_UP    = 2'd3;

   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 3'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   localparam logic signed [DATA_W-1:0] DATA_UNWRITTEN = -32'sd1;

   typedef struct packed {
      logic restart;
      logic advance;
   } sfm_cur_ctl_type;

endpackage

// ===== rtl/core/sfm_if.sv =====
// ----------------------------------------------------------------------------
// Spiral fill matrix channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfm_req_if;
   import sfm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] value;
   logic [IDX_W-1:0]         read_row;
   logic [IDX_W-1:0]         read_col;

   modport source (output valid, req_type, value, read_row, read_col, input ready);
   modport sink   (input valid, req_type, value, read_row, read_col, output ready);
endinterface

interface sfm_rsp_if;
   import sfm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   logic [IDX_W-1:0]         placed_row;
   logic [IDX_W-1:0]         placed_col;
   logic                     accepted;

   modport source (output valid, data, placed_row, placed_col, accepted, input ready);
   modport sink   (input valid, data, placed_row, placed_col, accepted, output ready);
endinterface

interface sfm_csr_if;
   import sfm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [SIZE_W-1:0]      wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/core/sfm_cursor.sv =====
// ----------------------------------------------------------------------------
// Spiral cursor
// Holds the four bounds, the cursor and the heading of the clockwise fill.
// ----------------------------------------------------------------------------
module sfm_cursor #(
   parameter int MAX_ROWS = sfm_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = sfm_pkg::MAX_COLS_DEFAULT,
   parameter int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfm_pkg::sfm_cur_ctl_type      ctl,
   input  logic [sfm_pkg::SIZE_W-1:0]    row_count,
   input  logic [sfm_pkg::SIZE_W-1:0]    col_count,
   output logic [ROW_W-1:0]              cursor_row,
   output logic [COL_W-1:0]              cursor_col,
   output logic                          filled
);
   import sfm_pkg::*;

   localparam int ROWS_RESET = (64 > MAX_ROWS) ? MAX_ROWS : 64;
   localparam int COLS_RESET = (64 > MAX_COLS) ? MAX_COLS : 64;

   logic [ROW_W-1:0] rows_m1;
   logic [COL_W-1:0] cols_m1;

   logic [ROW_W-1:0] top_ff, top_in, bottom_ff, bottom_in, row_ff, row_in;
   logic [COL_W-1:0] left_ff, left_in, right_ff, right_in, col_ff, col_in;
   logic [1:0]       heading_ff, heading_in;
   logic             filled_ff, filled_in;

   always_comb begin
      if (row_count == '0) begin
         rows_m1 = '0;
      end else if (SIZE_CMP_W'(row_count) > SIZE_CMP_W'(MAX_ROWS)) begin
         rows_m1 = ROW_W'(MAX_ROWS - 1);
      end else begin
         rows_m1 = ROW_W'(row_count - 1'b1);
      end
      if (col_count == '0) begin
         cols_m1 = '0;
      end else if (SIZE_CMP_W'(col_count) > SIZE_CMP_W'(MAX_COLS)) begin
         cols_m1 = COL_W'(MAX_COLS - 1);
      end else begin
         cols_m1 = COL_W'(col_count - 1'b1);
      end
   end

   always_comb begin
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      heading_in = heading_ff;
      filled_in  = filled_ff;
      if (ctl.restart) begin
         top_in     = '0;
         bottom_in  = rows_m1;
         left_in    = '0;
         right_in   = cols_m1;
         row_in     = '0;
         col_in     = '0;
         heading_in = HEAD_RIGHT;
         filled_in  = 1'b0;
      end else if (ctl.advance) begin
         case (heading_ff)
            HEAD_RIGHT: begin
               if (col_ff < right_ff) begin
                  col_in = col_ff + 1'b1;
               end else if (top_ff >= bottom_ff) begin
                  filled_in = 1'b1;
               end else begin
                  top_in     = top_ff + 1'b1;
                  heading_in = HEAD_DOWN;
                  row_in     = row_ff + 1'b1;
               end
            end
            HEAD_DOWN: begin
               if (row_ff < bottom_ff) begin
                  row_in = row_ff + 1'b1;
               end else if (right_ff <= left_ff) begin
                  filled_in = 1'b1;
               end else begin
                  right_in   = right_ff - 1'b1;
                  heading_in = HEAD_LEFT;
                  col_in     = col_ff - 1'b1;
               end
            end
            HEAD_LEFT: begin
               if (col_ff > left_ff) begin
                  col_in = col_ff - 1'b1;
               end else if (bottom_ff <= top_ff) begin
                  filled_in = 1'b1;
               end else begin
                  bottom_in  = bottom_ff - 1'b1;
                  heading_in = HEAD_UP;
                  row_in     = row_ff - 1'b1;
               end
            end
            default: begin
               if (row_ff > top_ff) begin
                  row_in = row_ff - 1'b1;
               end else if (left_ff >= right_ff) begin
                  filled_in = 1'b1;
               end else begin
                  left_in    = left_ff + 1'b1;
                  heading_in = HEAD_RIGHT;
                  col_in     = col_ff + 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= '0;
         bottom_ff  <= ROW_W'(ROWS_RESET - 1);
         left_ff    <= '0;
         right_ff   <= COL_W'(COLS_RESET - 1);
         row_ff     <= '0;
         col_ff     <= '0;
         heading_ff <= HEAD_RIGHT;
         filled_ff  <= 1'b0;
      end else begin
         top_ff     <= top_in;
         bottom_ff  <= bottom_in;
         left_ff    <= left_in;
         right_ff   <= right_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         heading_ff <= heading_in;
         filled_ff  <= filled_in;
      end
   end

   assign cursor_row = row_ff;
   assign cursor_col = col_ff;
   assign filled     = filled_ff;

endmodule

// ===== rtl/core/spiral_fill_matrix.sv =====
// ----------------------------------------------------------------------------
// Spiral fill matrix
// Places pushed values in clockwise spiral order and answers cell reads.
// ----------------------------------------------------------------------------
// The req_if channel carries push, read and clear requests; each request
// yields exactly one response on rsp_if. The csr_if channel writes the row
// and column counts, which take effect at the next clear request.
// A push, clear or unknown request is answered from the response register
// in the cycle after acceptance, and pushes can be taken every cycle while
// the receiver keeps up. A read goes through the cell memory, whose read
// port is registered, and then through the response register; the next
// request is taken once the read response has been issued. One request is
// in flight at a time. Cells are tagged with a three-bit clear epoch, so a
// clear request needs no sweep, except that every seventh clear and every
// reset start a sweep over all MAX_ROWS * MAX_COLS cells that erases the
// tags; no request is taken during the sweep, while register writes still
// are. When the receiver stalls, the response register holds and new
// requests wait until it is free.
// ----------------------------------------------------------------------------
module spiral_fill_matrix #(
   parameter int MAX_ROWS = sfm_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = sfm_pkg::MAX_COLS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   sfm_req_if.sink      req_if,
   sfm_rsp_if.source    rsp_if,
   sfm_csr_if.sink      csr_if
);
   import sfm_pkg::*;

`include "assert_macros.svh"

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int MEM_W  = EPOCH_W + DATA_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [EPOCH_W-1:0]      epoch_ff, epoch_in;
   logic                    oob_ff, oob_in;
   logic [SIZE_W-1:0]       row_count_ff, row_count_in, col_count_ff, col_count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [IDX_W-1:0]        rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic                    rsp_acc_ff, rsp_acc_in;

   logic [MEM_W-1:0]        cell_mem [CELLS];
   logic [MEM_W-1:0]        mem_rdata_ff;
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [MEM_W-1:0]        mem_wdata;

   sfm_cur_ctl_type         cur_ctl;
   logic [ROW_W-1:0]        cur_row;
   logic [COL_W-1:0]        cur_col;
   logic                    cur_filled;

   logic                    out_free, req_acc, push_place, rd_hit;

   sfm_cursor #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .ROW_W    (ROW_W),
      .COL_W    (COL_W)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .ctl        (cur_ctl),
      .row_count  (row_count_ff),
      .col_count  (col_count_ff),
      .cursor_row (cur_row),
      .cursor_col (cur_col),
      .filled     (cur_filled)
   );

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE) && out_free;
   assign req_acc       = req_if.valid && req_if.ready;
   assign push_place    = req_acc && (req_if.req_type == REQ_PUSH) && !cur_filled;
   assign csr_if.ready  = 1'b1;
   assign rd_hit        = !oob_ff && (mem_rdata_ff[MEM_W-1 -: EPOCH_W] == epoch_ff);

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_ROW_COUNT: row_count_in = csr_if.wdata;
            CSR_COL_COUNT: col_count_in = csr_if.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      epoch_in     = epoch_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_acc_in   = rsp_acc_ff;
      mem_we       = 1'b0;
      mem_waddr    = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(MAX_COLS) + ADDR_W'(cur_col));
      mem_wdata    = {epoch_ff, req_if.value};
      mem_re       = 1'b0;
      mem_raddr    = ADDR_W'(ADDR_W'(req_if.read_row) * ADDR_W'(MAX_COLS)
                             + ADDR_W'(req_if.read_col));
      cur_ctl      = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = {EPOCH_NONE, {DATA_W{1'b0}}};
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_row_in   = '0;
               rsp_col_in   = '0;
               rsp_acc_in   = 1'b0;
               case (req_if.req_type)
                  REQ_PUSH: begin
                     rsp_data_in = req_if.value;
                     if (!cur_filled) begin
                        mem_we          = 1'b1;
                        rsp_row_in      = IDX_W'(cur_row);
                        rsp_col_in      = IDX_W'(cur_col);
                        rsp_acc_in      = 1'b1;
                        cur_ctl.advance = 1'b1;
                     end
                  end
                  REQ_READ: begin
                     rsp_valid_in = 1'b0;
                     mem_re       = 1'b1;
                     oob_in       = (32'(req_if.read_row) >= MAX_ROWS)
                                 || (32'(req_if.read_col) >= MAX_COLS);
                     state_in     = ST_READ;
                  end
                  REQ_CLEAR: begin
                     cur_ctl.restart = 1'b1;
                     if (epoch_ff == EPOCH_LAST) begin
                        epoch_in   = EPOCH_FIRST;
                        clr_cnt_in = '0;
                        state_in   = ST_CLEAR;
                     end else begin
                        epoch_in = epoch_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_hit ? $signed(mem_rdata_ff[DATA_W-1:0]) : DATA_UNWRITTEN;
               rsp_row_in   = '0;
               rsp_col_in   = '0;
               rsp_acc_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= cell_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         epoch_ff     <= EPOCH_FIRST;
         oob_ff       <= 1'b0;
         row_count_ff <= SIZE_RESET;
         col_count_ff <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         epoch_ff     <= epoch_in;
         oob_ff       <= oob_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.data       = rsp_data_ff;
   assign rsp_if.placed_row = rsp_row_ff;
   assign rsp_if.placed_col = rsp_col_ff;
   assign rsp_if.accepted   = rsp_acc_ff;

   `SFM_ASSERT_IMPL(a_no_req_in_sweep, clock, reset, state_ff == ST_CLEAR, !req_acc, "request accepted during clearing sweep")
   `SFM_ASSERT_NEXT(a_push_answered, clock, reset, push_place, rsp_valid_ff && rsp_acc_ff, "placed push not answered as accepted")
   `SFM_ASSERT_NEXT(a_read_answered, clock, reset, (state_ff == ST_READ) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "read response not issued")
   `SFM_ASSERT_IMPL(a_epoch_live, clock, reset, 1'b1, epoch_ff != EPOCH_NONE, "current epoch equals the erased tag")

endmodule
